// ----- hw/rtl/ofd_pkg.sv -----
// ----------------------------------------------------------------------------
// ofd_pkg: shared definitions for the occupancy frontier detector
// Field widths, register indexes, cell classes and the cell classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ofd_pkg;

    // field and register widths
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CELL_W    = 8;
    localparam int IDX_W     = 20;

    // default map limits and register reset value
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int GRID_DIM_RESET = 1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // cell classes kept in the line store
    localparam int CLS_W   = 2;
    localparam int ENTRY_W = 2 * CLS_W;

    typedef logic [CLS_W-1:0]   t_cls;
    typedef logic [ENTRY_W-1:0] t_entry;

    localparam t_cls CLS_KNOWN    = 2'd0;
    localparam t_cls CLS_UNKNOWN  = 2'd1;
    localparam t_cls CLS_OCCUPIED = 2'd2;

    // raw occupancy codes
    localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 8'hFF;
    localparam logic [CELL_W-1:0] CELL_OCCUPIED = 8'd100;

    // map a raw occupancy value to its class
    function automatic t_cls classify(input logic [CELL_W-1:0] value);
        t_cls cls;
        if (value == CELL_UNKNOWN) begin
            cls = CLS_UNKNOWN;
        end else if (value == CELL_OCCUPIED) begin
            cls = CLS_OCCUPIED;
        end else begin
            cls = CLS_KNOWN;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ofd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ofd_cfg_regs: map size registers
// Holds the clamped grid width and height in the forms the datapath uses.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_cfg_regs #(
    parameter int MAX_WIDTH  = ofd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ofd_pkg::DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_wr_en,
    input  wire logic [ofd_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [ofd_pkg::CFG_W-1:0]    i_wr_data,
    output logic [WW-1:0]                     o_w_eff,
    output logic [XW-1:0]                     o_w_m1,
    output logic [YW-1:0]                     o_h_m1
);
    import ofd_pkg::*;

    localparam int RST_W = (GRID_DIM_RESET > MAX_WIDTH)  ? MAX_WIDTH  : GRID_DIM_RESET;
    localparam int RST_H = (GRID_DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_DIM_RESET;

    logic [WW-1:0] r_w_eff, n_w_eff;
    logic [XW-1:0] r_w_m1;
    logic [YW-1:0] r_h_m1, n_h_m1;

    // clamp written values into 1..max
    always_comb begin
        if (i_wr_data == '0) begin
            n_w_eff = WW'(1);
            n_h_m1  = '0;
        end else begin
            if (int'(i_wr_data) > MAX_WIDTH) begin
                n_w_eff = WW'(MAX_WIDTH);
            end else begin
                n_w_eff = WW'(i_wr_data);
            end
            if (int'(i_wr_data) > MAX_HEIGHT) begin
                n_h_m1 = YW'(MAX_HEIGHT - 1);
            end else begin
                n_h_m1 = YW'(i_wr_data - CFG_W'(1));
            end
        end
    end

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= WW'(RST_W);
            r_w_m1  <= XW'(RST_W - 1);
            r_h_m1  <= YW'(RST_H - 1);
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_GRID_WIDTH: begin
                    r_w_eff <= n_w_eff;
                    r_w_m1  <= XW'(n_w_eff - WW'(1));
                end
                REG_GRID_HEIGHT: begin
                    r_h_m1 <= n_h_m1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_w_eff = r_w_eff;
    assign o_w_m1  = r_w_m1;
    assign o_h_m1  = r_h_m1;

endmodule

`default_nettype wire

// ----- hw/rtl/ofd_position.sv -----
// ----------------------------------------------------------------------------
// ofd_position: raster position counters
// Column and row of the next cell, wrapping at the row and map ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_position #(
    parameter int MAX_WIDTH  = ofd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ofd_pkg::DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_advance,
    input  wire logic [XW-1:0] i_w_m1,
    input  wire logic [YW-1:0] i_h_m1,
    output logic [XW-1:0]      o_col,
    output logic [YW-1:0]      o_row
);
    import ofd_pkg::*;

    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;

    // step on every accepted cell; "at or past" covers a shrunk map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            if (r_col >= i_w_m1) begin
                r_col <= '0;
                if (r_row >= i_h_m1) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + YW'(1);
                end
            end else begin
                r_col <= r_col + XW'(1);
            end
        end
    end

    assign o_col = r_col;
    assign o_row = r_row;

endmodule

`default_nettype wire

// ----- hw/rtl/ofd_line_store.sv -----
// ----------------------------------------------------------------------------
// ofd_line_store: two-row class line buffer
// One entry per column holding the classes of the two previous rows.
// One write port, two registered read ports with write-first bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_line_store #(
    parameter int DEPTH = ofd_pkg::DEF_MAX_WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rd_en,
    input  wire logic [AW-1:0]           i_rd_addr_a,
    input  wire logic [AW-1:0]           i_rd_addr_b,
    output ofd_pkg::t_entry              o_rd_data_a,
    output ofd_pkg::t_entry              o_rd_data_b,
    input  wire logic                    i_wr_en,
    input  wire logic [AW-1:0]           i_wr_addr,
    input  wire ofd_pkg::t_entry         i_wr_data
);
    import ofd_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read ports, same-edge write is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= (i_wr_en && (i_wr_addr == i_rd_addr_a)) ? i_wr_data
                                                              : r_mem[i_rd_addr_a];
            r_rd_b <= (i_wr_en && (i_wr_addr == i_rd_addr_b)) ? i_wr_data
                                                              : r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

// ----- hw/rtl/ofd_judge.sv -----
// ----------------------------------------------------------------------------
// ofd_judge: frontier decision stage and result register
// Holds the cell whose line-store reads are in flight, judges the cell above
// it, writes the shifted classes back and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_judge #(
    parameter int MAX_WIDTH  = ofd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ofd_pkg::DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // accepted cell
    input  wire logic                     i_accept,
    input  wire logic [XW-1:0]            i_col,
    input  wire logic [YW-1:0]            i_row,
    input  wire ofd_pkg::t_cls            i_cls,
    // line store
    input  wire ofd_pkg::t_entry          i_rd_a,
    input  wire ofd_pkg::t_entry          i_rd_b,
    output logic                          o_wr_en,
    output logic [XW-1:0]                 o_wr_addr,
    output ofd_pkg::t_entry               o_wr_data,
    // map size
    input  wire logic [WW-1:0]            i_w_eff,
    input  wire logic [XW-1:0]            i_w_m1,
    input  wire logic [YW-1:0]            i_h_m1,
    // flow control
    output logic                          o_in_stall,
    input  wire logic                     i_out_stall,
    // result
    output logic                          o_out_valid,
    output logic [ofd_pkg::IDX_W-1:0]     o_cell_index,
    output logic                          o_is_frontier,
    output logic                          o_last_of_map
);
    import ofd_pkg::*;

    logic              r_s1_valid;
    logic [XW-1:0]     r_s1_col;
    logic [YW-1:0]     r_s1_row;
    t_cls              r_s1_cls;
    t_cls              r_left;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_cell_index;
    logic              r_is_frontier;
    logic              r_last_of_map;

    logic              s1_adv;
    t_cls              center, up, right, left, down;
    logic [YW-1:0]     jy;
    logic              border, occ, unk;
    logic              n_frontier, n_last, n_emit;
    logic [IDX_W-1:0]  prod;
    logic [IDX_W-1:0]  n_index;

    // stage advances when the result register is free or being taken
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;

    // 4-neighbourhood of the judged cell
    always_comb begin
        center = i_rd_a[CLS_W-1:0];
        up     = i_rd_a[ENTRY_W-1:CLS_W];
        right  = i_rd_b[CLS_W-1:0];
        left   = r_left;
        down   = r_s1_cls;
    end

    // frontier test and result fields
    always_comb begin
        jy     = r_s1_row - YW'(1);
        n_emit = (r_s1_row != '0);
        border = (r_s1_col == '0) || (r_s1_col >= i_w_m1) ||
                 (jy == '0) || (jy >= i_h_m1);
        occ    = (left == CLS_OCCUPIED) || (right == CLS_OCCUPIED) ||
                 (up == CLS_OCCUPIED) || (down == CLS_OCCUPIED);
        unk    = (left == CLS_UNKNOWN) || (right == CLS_UNKNOWN) ||
                 (up == CLS_UNKNOWN) || (down == CLS_UNKNOWN);
        n_frontier = !border && (center != CLS_UNKNOWN) && !occ && unk;
        n_last     = (r_s1_row >= i_h_m1) && (r_s1_col >= i_w_m1);
        prod       = IDX_W'(jy) * IDX_W'(i_w_eff);
        n_index    = prod + IDX_W'(r_s1_col);
    end

    // shift the column's classes down one row
    assign o_wr_en   = s1_adv;
    assign o_wr_addr = r_s1_col;
    assign o_wr_data = {center, r_s1_cls};

    // decision stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // decision stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col <= i_col;
            r_s1_row <= i_row;
            r_s1_cls <= i_cls;
        end
        if (s1_adv) begin
            r_left <= center;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= n_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_cell_index  <= n_index;
            r_is_frontier <= n_frontier;
            r_last_of_map <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_index  = r_cell_index;
    assign o_is_frontier = r_is_frontier;
    assign o_last_of_map = r_last_of_map;

endmodule

`default_nettype wire

// ----- hw/rtl/occupancy_frontier_detect_top.sv -----
// ----------------------------------------------------------------------------
// occupancy_frontier_detect_top: streaming occupancy-grid frontier detector
// Cells arrive in raster order on the input channel (i_in_valid / o_in_stall).
// When a cell of row y >= 1 is taken, the cell directly above it is judged and
// one result (index, frontier flag, last-of-map flag) leaves on the output
// channel (o_out_valid / i_out_stall). Row 0 cells produce no result; the last
// row is never judged. Grid width and height are set through the config write
// port (i_cfg_valid / o_cfg_ready, always ready); the user must write them only
// while the block is idle, the block itself does not enforce it. Throughput
// is one cell per cycle while the receiver does not stall. The line-store read
// is registered with the cell, then the decision goes to the result register.
// When the receiver stalls, the result register holds and the decision stage
// keeps one cell, so the input stalls only once both are full.
// Reset clears the position counters and pipeline valids and sets both
// dimensions to 1024 (clamped to the maximum); the line store is not cleared,
// and entries read before being written only feed border or unemitted results.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_frontier_detect_top #(
    parameter int MAX_WIDTH  = ofd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ofd_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // cell input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ofd_pkg::CELL_W-1:0]    i_cell_value,
    // result output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [ofd_pkg::IDX_W-1:0]          o_cell_index,
    output logic                               o_is_frontier,
    output logic                               o_last_of_map,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ofd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ofd_pkg::CFG_W-1:0]     i_cfg_data
);
    import ofd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic          in_xfer;
    logic [WW-1:0] w_eff;
    logic [XW-1:0] w_m1;
    logic [YW-1:0] h_m1;
    logic [XW-1:0] col;
    logic [YW-1:0] row;
    logic [XW-1:0] addr_right;
    t_cls          in_cls;
    t_entry        rd_a, rd_b;
    logic          wr_en;
    logic [XW-1:0] wr_addr;
    t_entry        wr_data;

    // input transfer and cell class
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign in_cls      = classify(i_cell_value);
    assign o_cfg_ready = 1'b1;

    // right neighbour column, kept inside the store
    assign addr_right = (col == XW'(MAX_WIDTH - 1)) ? '0 : col + XW'(1);

    ofd_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_w_eff    (w_eff),
        .o_w_m1     (w_m1),
        .o_h_m1     (h_m1)
    );

    ofd_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_xfer),
        .i_w_m1    (w_m1),
        .i_h_m1    (h_m1),
        .o_col     (col),
        .o_row     (row)
    );

    ofd_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk       (i_clk),
        .i_rd_en     (in_xfer),
        .i_rd_addr_a (col),
        .i_rd_addr_b (addr_right),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data)
    );

    ofd_judge #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_judge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_xfer),
        .i_col         (col),
        .i_row         (row),
        .i_cls         (in_cls),
        .i_rd_a        (rd_a),
        .i_rd_b        (rd_b),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_w_eff       (w_eff),
        .i_w_m1        (w_m1),
        .i_h_m1        (h_m1),
        .o_in_stall    (o_in_stall),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_cell_index  (o_cell_index),
        .o_is_frontier (o_is_frontier),
        .o_last_of_map (o_last_of_map)
    );

endmodule

`default_nettype wire
